### hdl/hmq_pkg.sv
// shared codes, port widths and result record of the binary min-heap queue
`timescale 1ns / 1ps
`default_nettype none

package hmq_pkg;

    // port widths of the request and result fields
    localparam int KEY_PORT_W = 32;
    localparam int TAG_PORT_W = 16;
    localparam int FILL_W     = 11;
    localparam int STATUS_W   = 2;

    // request mode codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [KEY_PORT_W-1:0] head_key;
        logic [TAG_PORT_W-1:0] head_tag;
        logic [FILL_W-1:0]     fill_level;
    } t_res;

endpackage

`default_nettype wire

### hdl/hmq_ram.sv
// heap entry memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module hmq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/hmq_engine.sv
// sift-up / sift-down sequencer working on the heap memory
`timescale 1ns / 1ps
`default_nettype none

module hmq_engine #(
    parameter int DEPTH    = 1024,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_req_valid,
    output logic                                   o_req_ready,
    input  wire logic                              i_mode,
    input  wire logic [hmq_pkg::KEY_PORT_W-1:0]    i_entry_key,
    input  wire logic [hmq_pkg::TAG_PORT_W-1:0]    i_entry_tag,
    output logic                                   o_res_valid,
    input  wire logic                              i_res_ready,
    output hmq_pkg::t_res                          o_res,
    output logic                                   o_mem_we,
    output logic [$clog2(DEPTH)-1:0]               o_mem_waddr,
    output logic [KEY_BITS+TAG_BITS-1:0]           o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0]               o_mem_raddr,
    input  wire logic [KEY_BITS+TAG_BITS-1:0]      i_mem_rdata
);

    import hmq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 2;
    localparam int EW = KEY_BITS + TAG_BITS;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP      = 8'b0000_0010,
        S_DQ_ROOT = 8'b0000_0100,
        S_DQ_LAST = 8'b0000_1000,
        S_DN_L    = 8'b0001_0000,
        S_DN_CMP  = 8'b0010_0000,
        S_DN_PUT  = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_pos, n_pos;
    logic [EW-1:0]       r_cur, n_cur;
    logic [EW-1:0]       r_left, n_left;
    logic                r_use_r, n_use_r;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [EW-1:0]       r_head, n_head;

    logic [EW-1:0]       in_entry;
    logic [KEY_BITS-1:0] cur_key, rd_key, left_key, best_key;
    logic [IW-1:0]       pos_w, cnt_w, parent_w, gparent_w, lc_w, rc_w;
    logic [IW-1:0]       child_w, next_lc_w;
    logic                l_lt, r_lt, child_go;
    logic [EW-1:0]       child_entry;

    assign in_entry = {KEY_BITS'(i_entry_key), TAG_BITS'(i_entry_tag)};
    assign cur_key  = r_cur[EW-1:TAG_BITS];
    assign rd_key   = i_mem_rdata[EW-1:TAG_BITS];
    assign left_key = r_left[EW-1:TAG_BITS];

    assign pos_w     = IW'(r_pos);
    assign cnt_w     = IW'(r_count);
    assign parent_w  = (pos_w - IW'(1)) >> 1;
    assign gparent_w = (parent_w - IW'(1)) >> 1;
    assign lc_w      = (pos_w << 1) + IW'(1);
    assign rc_w      = (pos_w << 1) + IW'(2);

    // pick among current, left and right child; ties keep the earlier one
    assign l_lt        = left_key < cur_key;
    assign best_key    = l_lt ? left_key : cur_key;
    assign r_lt        = r_use_r && (rd_key < best_key);
    assign child_go    = l_lt || r_lt;
    assign child_w     = r_lt ? rc_w : lc_w;
    assign child_entry = r_lt ? i_mem_rdata : r_left;
    assign next_lc_w   = (child_w << 1) + IW'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_left      = r_left;
        n_use_r     = r_use_r;
        n_status    = r_status;
        n_head      = r_head;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos;
        o_mem_wdata = r_cur;
        o_mem_raddr = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_status = ST_OK;
                    n_head   = '0;
                    if (i_mode == MODE_ENQ) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_pos       = AW'(r_count);
                            n_cur       = in_entry;
                            n_count     = r_count + CW'(1);
                            o_mem_raddr = AW'((cnt_w - IW'(1)) >> 1);
                            n_state     = S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_count     = r_count - CW'(1);
                            o_mem_raddr = '0;
                            n_state     = S_DQ_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                o_mem_we = 1'b1;
                if (r_pos != '0 && rd_key > cur_key) begin
                    // parent moves down, keep climbing
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = AW'(parent_w);
                    o_mem_raddr = AW'(gparent_w);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DQ_ROOT: begin
                n_head      = i_mem_rdata;
                o_mem_raddr = AW'(r_count);
                n_state     = S_DQ_LAST;
            end
            S_DQ_LAST: begin
                n_cur = i_mem_rdata;
                n_pos = '0;
                if (IW'(1) < cnt_w) begin
                    o_mem_raddr = AW'(1);
                    n_state     = S_DN_L;
                end else begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = '0;
                    o_mem_wdata = i_mem_rdata;
                    n_state     = S_FIN;
                end
            end
            S_DN_L: begin
                n_left = i_mem_rdata;
                if (rc_w < cnt_w) begin
                    o_mem_raddr = AW'(rc_w);
                    n_use_r     = 1'b1;
                end else begin
                    n_use_r = 1'b0;
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_mem_we = 1'b1;
                if (child_go) begin
                    o_mem_wdata = child_entry;
                    n_pos       = AW'(child_w);
                    if (next_lc_w < cnt_w) begin
                        o_mem_raddr = AW'(next_lc_w);
                        n_state     = S_DN_L;
                    end else begin
                        n_state = S_DN_PUT;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_PUT: begin
                o_mem_we = 1'b1;
                n_state  = S_FIN;
            end
            S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_use_r  <= n_use_r;
        r_status <= n_status;
        r_head   <= n_head;
    end

    assign o_res.status     = r_status;
    assign o_res.head_key   = KEY_PORT_W'(r_head[EW-1:TAG_BITS]);
    assign o_res.head_tag   = TAG_PORT_W'(r_head[TAG_BITS-1:0]);
    assign o_res.fill_level = FILL_W'(r_count);

endmodule

`default_nettype wire

### hdl/binary_min_heap_queue.sv
// top level of the binary min-heap priority queue
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | request   | i_in_valid / o_in_ready | i_mode, i_entry_key, i_entry_tag
//   out     | result    | o_out_valid/i_out_ready | o_status, o_head_key, o_head_tag,
//           |           |                         | o_fill_level
//
// one request at a time; the heap memory has a single read port, which sets the pace
// enqueue: one read per level climbed, up to log2(DEPTH) levels
// dequeue: reads the root, then the last entry; when more than one entry remains, the
// sift-down reads the left and then, if present, the right child at each level moved down
// rejected requests (full or empty) go straight to the result
// reset empties the queue through the entry count; memory contents need no clearing
// a result waiting in the output register does not block the next request
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue #(
    parameter int DEPTH    = 1024,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_in_valid,
    output logic                                            o_in_ready,
    input  wire logic                                       i_mode,
    input  wire logic [hmq_pkg::KEY_PORT_W-1:0]             i_entry_key,
    input  wire logic [hmq_pkg::TAG_PORT_W-1:0]             i_entry_tag,
    output logic                                            o_out_valid,
    input  wire logic                                       i_out_ready,
    output logic [hmq_pkg::STATUS_W-1:0]                    o_status,
    output logic [hmq_pkg::KEY_PORT_W-1:0]                  o_head_key,
    output logic [hmq_pkg::TAG_PORT_W-1:0]                  o_head_tag,
    output logic [hmq_pkg::FILL_W-1:0]                      o_fill_level
);

    import hmq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = KEY_BITS + TAG_BITS;

    // engine to memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    // engine result toward the output register
    logic res_valid;
    logic res_ready;
    t_res res;

    // output register
    logic r_out_valid;
    t_res r_out;
    logic out_load;

    hmq_engine #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_mode      (i_mode),
        .i_entry_key (i_entry_key),
        .i_entry_tag (i_entry_tag),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    hmq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output slot is free when empty or being drained this cycle
    assign res_ready = !r_out_valid || i_out_ready;
    assign out_load  = res_valid && res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_head_key   = r_out.head_key;
    assign o_head_tag   = r_out.head_tag;
    assign o_fill_level = r_out.fill_level;

endmodule

`default_nettype wire

### hdl/hmq_chk.sv
// port-level checker for the binary min-heap queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module hmq_chk #(
    parameter int DEPTH = 1024
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [hmq_pkg::STATUS_W-1:0]      o_status,
    input wire logic [hmq_pkg::KEY_PORT_W-1:0]    o_head_key,
    input wire logic [hmq_pkg::TAG_PORT_W-1:0]    o_head_tag,
    input wire logic [hmq_pkg::FILL_W-1:0]        o_fill_level
);

    import hmq_pkg::*;

    // rejected requests carry no head entry
    a_reject_no_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY || o_status == ST_FULL)
        |-> o_head_key == '0 && o_head_tag == '0)
        else $error("rejected request returned a head entry");

    // dequeue on empty leaves the queue empty
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_fill_level == '0)
        else $error("empty status with nonzero fill level");

    // enqueue on full reports a full queue
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_fill_level == FILL_W'(DEPTH))
        else $error("full status with fill level below depth");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready
        |=> o_out_valid && $stable(o_status) && $stable(o_head_key)
            && $stable(o_head_tag) && $stable(o_fill_level))
        else $error("stalled result changed");

endmodule

bind binary_min_heap_queue hmq_chk #(
    .DEPTH (DEPTH)
) u_hmq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_head_key   (o_head_key),
    .o_head_tag   (o_head_tag),
    .o_fill_level (o_fill_level)
);

`default_nettype wire
